// ===== design/owt_pkg.sv =====
// Shared types, constants and command table of the 1-Wire temperature reader.
package owt_pkg;

  localparam int unsigned ReadBytesDef = 9;

  localparam logic [19:0] ConvWaitRst   = 20'd750000;
  localparam logic [9:0]  ResetLowRst   = 10'd480;
  localparam logic [9:0]  PresSampleRst = 10'd70;
  localparam logic [9:0]  ResetTailRst  = 10'd410;
  localparam logic [9:0]  SlotRst       = 10'd60;
  localparam logic [9:0]  ShortLowRst   = 10'd6;
  localparam logic [9:0]  ReadSampleRst = 10'd15;
  localparam logic [9:0]  RecoveryRst   = 10'd1;

  localparam logic [7:0] CmdSkipRom  = 8'hCC;
  localparam logic [7:0] CmdConvert  = 8'h44;
  localparam logic [7:0] CmdReadScr  = 8'hBE;

  typedef enum logic [2:0] {
    CFG_CONV_WAIT   = 3'd0,
    CFG_RESET_LOW   = 3'd1,
    CFG_PRES_SAMPLE = 3'd2,
    CFG_RESET_TAIL  = 3'd3,
    CFG_SLOT        = 3'd4,
    CFG_SHORT_LOW   = 3'd5,
    CFG_READ_SAMPLE = 3'd6,
    CFG_RECOVERY    = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_WR_LOW   = 4'd4,
    PH_WR_HIGH  = 4'd5,
    PH_CONV     = 4'd6,
    PH_RD_LOW   = 4'd7,
    PH_RD_WAIT  = 4'd8,
    PH_RD_TAIL  = 4'd9
  } phase_e;

  typedef struct packed {
    logic [19:0] conv_wait_us;
    logic [9:0]  reset_low_us;
    logic [9:0]  presence_sample_us;
    logic [9:0]  reset_tail_us;
    logic [9:0]  slot_us;
    logic [9:0]  short_low_us;
    logic [9:0]  read_sample_us;
    logic [9:0]  recovery_us;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic bus_level;
  } in_item_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic               valid_res;
    logic               no_presence;
    logic signed [15:0] temperature;
    logic               start_refused;
  } out_item_t;

  // Command sequence: skip-ROM, convert, skip-ROM, read scratchpad.
  function automatic logic [7:0] cmd_byte(input logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0:    b = CmdSkipRom;
      2'd1:    b = CmdConvert;
      2'd2:    b = CmdSkipRom;
      default: b = CmdReadScr;
    endcase
    return b;
  endfunction

endpackage

// ===== design/owt_cfg.sv =====
// Timing register file of the 1-Wire temperature reader.
module owt_cfg import owt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [19:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.conv_wait_us       <= ConvWaitRst;
      cfg_q.reset_low_us       <= ResetLowRst;
      cfg_q.presence_sample_us <= PresSampleRst;
      cfg_q.reset_tail_us      <= ResetTailRst;
      cfg_q.slot_us            <= SlotRst;
      cfg_q.short_low_us       <= ShortLowRst;
      cfg_q.read_sample_us     <= ReadSampleRst;
      cfg_q.recovery_us        <= RecoveryRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CONV_WAIT:   cfg_q.conv_wait_us       <= cfg_wdata_i;
        CFG_RESET_LOW:   cfg_q.reset_low_us       <= cfg_wdata_i[9:0];
        CFG_PRES_SAMPLE: cfg_q.presence_sample_us <= cfg_wdata_i[9:0];
        CFG_RESET_TAIL:  cfg_q.reset_tail_us      <= cfg_wdata_i[9:0];
        CFG_SLOT:        cfg_q.slot_us            <= cfg_wdata_i[9:0];
        CFG_SHORT_LOW:   cfg_q.short_low_us       <= cfg_wdata_i[9:0];
        CFG_READ_SAMPLE: cfg_q.read_sample_us     <= cfg_wdata_i[9:0];
        CFG_RECOVERY:    cfg_q.recovery_us        <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/owt_dur.sv =====
// Phase length select: ticks the current phase lasts, never below one.
module owt_dur import owt_pkg::*; (
  input  phase_e      phase_i,
  input  logic        bit_one_i,
  input  cfg_t        cfg_i,
  output logic [19:0] len_o
);

  function automatic logic [9:0] sat_sub(input logic [9:0] a, input logic [9:0] b);
    return (a > b) ? (a - b) : 10'd0;
  endfunction

  logic [19:0] d;

  always_comb begin
    case (phase_i)
      PH_RST_LOW:  d = {10'd0, cfg_i.reset_low_us};
      PH_RST_WAIT: d = {10'd0, cfg_i.presence_sample_us};
      PH_RST_TAIL: d = {10'd0, cfg_i.reset_tail_us};
      PH_WR_LOW:   d = {10'd0, bit_one_i ? cfg_i.short_low_us : cfg_i.slot_us};
      PH_WR_HIGH:  d = {10'd0, bit_one_i ? sat_sub(cfg_i.slot_us, cfg_i.short_low_us)
                                         : cfg_i.recovery_us};
      PH_CONV:     d = cfg_i.conv_wait_us;
      PH_RD_LOW:   d = {10'd0, cfg_i.short_low_us};
      PH_RD_WAIT:  d = {10'd0, sat_sub(cfg_i.read_sample_us, cfg_i.short_low_us)};
      PH_RD_TAIL:  d = {10'd0, sat_sub(cfg_i.slot_us, cfg_i.read_sample_us)};
      default:     d = 20'd1;
    endcase
    len_o = (d == 20'd0) ? 20'd1 : d;
  end

endmodule

// ===== design/owt_seq.sv =====
// Bus sequencer: phase state machine, slot timer, bit and byte shifting.
module owt_seq import owt_pkg::*; #(
  parameter int unsigned READ_BYTES = ReadBytesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  localparam logic [3:0] RdBytes = 4'(READ_BYTES);

  phase_e      phase_q, phase_d;
  logic [19:0] timer_q, timer_d;
  logic [2:0]  bit_q, bit_d;
  logic [3:0]  byte_q, byte_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] temp_q, temp_d;
  logic [1:0]  status_q, status_d;
  logic [19:0] len;
  logic        done, refused;

  owt_dur u_dur (
    .phase_i   (phase_q),
    .bit_one_i (shift_q[0]),
    .cfg_i     (cfg_i),
    .len_o     (len)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      timer_q  <= '0;
      bit_q    <= '0;
      byte_q   <= '0;
      shift_q  <= '0;
      low_q    <= '0;
      temp_q   <= '0;
      status_q <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      timer_q  <= timer_d;
      bit_q    <= bit_d;
      byte_q   <= byte_d;
      shift_q  <= shift_d;
      low_q    <= low_d;
      temp_q   <= temp_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    timer_d  = timer_q;
    bit_d    = bit_q;
    byte_d   = byte_q;
    shift_d  = shift_q;
    low_d    = low_q;
    temp_d   = temp_q;
    status_d = status_q;
    done     = 1'b0;
    refused  = 1'b0;

    if (phase_q == PH_IDLE) begin
      if (item_i.start_req) begin
        phase_d = PH_RST_LOW;
        timer_d = '0;
        bit_d   = '0;
        byte_d  = '0;
      end
    end else begin
      refused = item_i.start_req;
      if (({1'b0, timer_q} + 21'd1) >= {1'b0, len}) begin
        timer_d = '0;
        case (phase_q)
          PH_RST_LOW:  phase_d = PH_RST_WAIT;
          PH_RST_WAIT: begin
            // high at the sample point means nobody answered
            shift_d = {7'd0, item_i.bus_level};
            phase_d = PH_RST_TAIL;
          end
          PH_RST_TAIL: begin
            if (shift_q[0]) begin
              phase_d  = PH_IDLE;
              done     = 1'b1;
              status_d = 2'b10;
            end else begin
              shift_d = cmd_byte(byte_q[1:0]);
              bit_d   = '0;
              phase_d = PH_WR_LOW;
            end
          end
          PH_WR_LOW:   phase_d = PH_WR_HIGH;
          PH_WR_HIGH: begin
            shift_d = {1'b0, shift_q[7:1]};
            bit_d   = bit_q + 3'd1;
            if (bit_d != 3'd0) begin
              phase_d = PH_WR_LOW;
            end else begin
              byte_d = byte_q + 4'd1;
              if (byte_d == 4'd2) begin
                phase_d = PH_CONV;
              end else if (byte_d >= 4'd4) begin
                byte_d  = '0;
                shift_d = '0;
                phase_d = PH_RD_LOW;
              end else begin
                shift_d = cmd_byte(byte_d[1:0]);
                phase_d = PH_WR_LOW;
              end
            end
          end
          PH_CONV: begin
            // resume the command list at the second skip-ROM
            byte_d  = 4'd2;
            phase_d = PH_RST_LOW;
          end
          PH_RD_LOW:   phase_d = PH_RD_WAIT;
          PH_RD_WAIT: begin
            shift_d = {item_i.bus_level, shift_q[7:1]};
            phase_d = PH_RD_TAIL;
          end
          PH_RD_TAIL: begin
            bit_d = bit_q + 3'd1;
            if (bit_d != 3'd0) begin
              phase_d = PH_RD_LOW;
            end else begin
              if (byte_q == 4'd0) begin
                low_d = shift_q;
              end else if (byte_q == 4'd1) begin
                temp_d = {shift_q, low_q};
              end
              byte_d = byte_q + 4'd1;
              if (byte_d >= RdBytes) begin
                phase_d  = PH_IDLE;
                done     = 1'b1;
                status_d = 2'b01;
              end else begin
                phase_d = PH_RD_LOW;
              end
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end else begin
        timer_d = timer_q + 20'd1;
      end
    end

    result_o.drive_low     = (phase_q == PH_RST_LOW) || (phase_q == PH_WR_LOW) ||
                             (phase_q == PH_RD_LOW);
    result_o.busy_res      = (phase_d != PH_IDLE);
    result_o.done_res      = done;
    result_o.valid_res     = status_d[0];
    result_o.no_presence   = status_d[1];
    result_o.temperature   = temp_d;
    result_o.start_refused = refused;
  end

endmodule

// ===== design/onewire_temperature_reader.sv =====
// Top level of the 1-Wire temperature reader: handshake, result register, checks.
//
// Feed one input item per microsecond tick on in_item_i (start request and the
// sampled line level). Each accepted item yields exactly one result item on
// out_item_o: the open-drain low drive for that tick, busy, a done pulse, the
// valid and no-presence flags of the last sequence and the Q12.4 temperature.
// The sequencer steps at the accept edge and its result lands in the output
// register, so a result is valid in the cycle after its item is accepted.
// Throughput is one item per cycle while the receiver takes results; the phase
// state machine and slot timer advance once per accepted item.
// in_ready_o is high while the output register is empty or being taken, so a
// stalled receiver holds the pending result and blocks new items until it
// takes it; no item is dropped.
// Timing registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i at
// any edge; write them while no sequence runs.
// Reset returns all timing registers to their defaults, the sequencer to idle
// with flags and temperature cleared, and empties the output register.
module onewire_temperature_reader import owt_pkg::*; #(
  parameter int unsigned READ_BYTES = ReadBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [19:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o
);

  cfg_t      cfg;
  out_item_t result;
  out_item_t out_q;
  logic      out_valid_q;
  logic      accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  owt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  owt_seq #(
    .READ_BYTES (READ_BYTES)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .item_i   (in_item_i),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // hold the pending item while the receiver stalls
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("result changed while stalled");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> !out_q.busy_res)
    else $error("done pulse while still busy");

  a_done_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> (out_q.valid_res ^ out_q.no_presence))
    else $error("sequence end without exactly one status flag");

  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.drive_low |-> out_q.busy_res)
    else $error("line driven low outside a sequence");

endmodule

// ===== bench/onewire_temperature_reader_tb.sv =====
// Self-checking bench for the 1-Wire temperature reader: sensor model, sequencer predictor, checks.
`timescale 1ns / 1ps

module onewire_temperature_reader_tb import owt_pkg::*;;

  localparam int unsigned READ_LEN = ReadBytesDef;
  localparam logic [31:0] CMD_SEQ = {CmdReadScr, CmdSkipRom, CmdConvert, CmdSkipRom};
  localparam logic [3:0]  CONV_AFTER_BYTES = 4'd2;
  localparam logic [3:0]  CMD_BYTES        = 4'd4;
  localparam logic [1:0]  FLAG_OK          = 2'b01;
  localparam logic [1:0]  FLAG_NO_PRESENCE = 2'b10;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = '0;
  logic [19:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;

  onewire_temperature_reader dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted sequencer state and timing registers
  cfg_t       cfg;
  phase_e     ph;
  logic [19:0] tmr;
  logic [2:0] bit_idx;
  logic [3:0] byte_cnt;
  logic [7:0] shreg;
  logic [7:0] lo_byte;
  logic [15:0] temp_q;
  logic [1:0] flags;

  // Sensor on the line: presence per reset and the scratchpad it returns
  logic [1:0]  sensor_present;
  logic [71:0] sensor_pad;

  out_item_t tick_results[$];
  int        mismatches = 0;
  bit        quiet = 1'b0;

  function automatic logic [19:0] sat_diff(input logic [9:0] a, input logic [9:0] b);
    return (a > b) ? 20'(a - b) : 20'd0;
  endfunction

  function automatic logic [19:0] phase_ticks();
    logic [19:0] d;
    case (ph)
      PH_RST_LOW:  d = 20'(cfg.reset_low_us);
      PH_RST_WAIT: d = 20'(cfg.presence_sample_us);
      PH_RST_TAIL: d = 20'(cfg.reset_tail_us);
      PH_WR_LOW:   d = 20'(shreg[0] ? cfg.short_low_us : cfg.slot_us);
      PH_WR_HIGH:  d = shreg[0] ? sat_diff(cfg.slot_us, cfg.short_low_us)
                                : 20'(cfg.recovery_us);
      PH_CONV:     d = cfg.conv_wait_us;
      PH_RD_LOW:   d = 20'(cfg.short_low_us);
      PH_RD_WAIT:  d = sat_diff(cfg.read_sample_us, cfg.short_low_us);
      PH_RD_TAIL:  d = sat_diff(cfg.slot_us, cfg.read_sample_us);
      default:     d = 20'd1;
    endcase
    return (d == 20'd0) ? 20'd1 : d;
  endfunction

  // One microsecond tick of the sequencer; returns the result it causes.
  function automatic out_item_t sequencer_step(input in_item_t it);
    out_item_t r;
    r = '0;
    r.drive_low = (ph == PH_RST_LOW) || (ph == PH_WR_LOW) || (ph == PH_RD_LOW);
    if (ph == PH_IDLE) begin
      if (it.start_req) begin
        ph = PH_RST_LOW;
        tmr = '0;
        bit_idx = '0;
        byte_cnt = '0;
      end
    end else begin
      r.start_refused = it.start_req;
      if (int'(tmr) + 1 >= int'(phase_ticks())) begin
        tmr = '0;
        case (ph)
          PH_RST_LOW: ph = PH_RST_WAIT;
          PH_RST_WAIT: begin
            // high at the sample point means nobody answered
            shreg = {7'd0, it.bus_level};
            ph = PH_RST_TAIL;
          end
          PH_RST_TAIL: begin
            if (shreg[0]) begin
              ph = PH_IDLE;
              r.done_res = 1'b1;
              flags = FLAG_NO_PRESENCE;
            end else begin
              shreg = CMD_SEQ[byte_cnt[1:0]*8 +: 8];
              bit_idx = '0;
              ph = PH_WR_LOW;
            end
          end
          PH_WR_LOW: ph = PH_WR_HIGH;
          PH_WR_HIGH: begin
            shreg = shreg >> 1;
            bit_idx = bit_idx + 3'd1;
            if (bit_idx != 3'd0) begin
              ph = PH_WR_LOW;
            end else begin
              byte_cnt = byte_cnt + 4'd1;
              if (byte_cnt == CONV_AFTER_BYTES) begin
                ph = PH_CONV;
              end else if (byte_cnt >= CMD_BYTES) begin
                byte_cnt = '0;
                shreg = '0;
                ph = PH_RD_LOW;
              end else begin
                shreg = CMD_SEQ[byte_cnt[1:0]*8 +: 8];
                ph = PH_WR_LOW;
              end
            end
          end
          PH_CONV: begin
            byte_cnt = CONV_AFTER_BYTES;
            ph = PH_RST_LOW;
          end
          PH_RD_LOW: ph = PH_RD_WAIT;
          PH_RD_WAIT: begin
            shreg = {it.bus_level, shreg[7:1]};
            ph = PH_RD_TAIL;
          end
          PH_RD_TAIL: begin
            bit_idx = bit_idx + 3'd1;
            if (bit_idx != 3'd0) begin
              ph = PH_RD_LOW;
            end else begin
              if (byte_cnt == 4'd0) lo_byte = shreg;
              else if (byte_cnt == 4'd1) temp_q = {shreg, lo_byte};
              byte_cnt = byte_cnt + 4'd1;
              if (byte_cnt >= READ_LEN) begin
                ph = PH_IDLE;
                r.done_res = 1'b1;
                flags = FLAG_OK;
              end else begin
                ph = PH_RD_LOW;
              end
            end
          end
          default: ph = PH_IDLE;
        endcase
      end else begin
        tmr = tmr + 20'd1;
      end
    end
    r.busy_res = (ph != PH_IDLE);
    r.valid_res = flags[0];
    r.no_presence = flags[1];
    r.temperature = temp_q;
    return r;
  endfunction

  function automatic logic [71:0] sensor_bytes(input logic [15:0] temp);
    logic [31:0] a;
    logic [31:0] b;
    logic [7:0]  c;
    a = $urandom;
    b = $urandom;
    c = 8'($urandom_range(0, 255));
    return {c, a, b[31:16], temp};
  endfunction

  function automatic logic [9:0] pick_us();
    return ($urandom_range(0, 7) == 0) ? 10'($urandom_range(4, 12)) : 10'($urandom_range(0, 3));
  endfunction

  function automatic cfg_t random_timing();
    cfg_t c;
    c.conv_wait_us       = 20'($urandom_range(0, 20));
    c.reset_low_us       = pick_us();
    c.presence_sample_us = pick_us();
    c.reset_tail_us      = pick_us();
    c.slot_us            = pick_us();
    c.short_low_us       = pick_us();
    c.read_sample_us     = pick_us();
    c.recovery_us        = pick_us();
    return c;
  endfunction

  task automatic field_check(input string name, input logic signed [16:0] e,
                             input logic signed [16:0] a);
    if (a !== e) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      mismatches++;
    end
  endtask

  // Enter at a falling edge; leave at the falling edge after the item is taken.
  task automatic send_tick(input in_item_t it, output out_item_t want);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    want = sequencer_step(it);
    tick_results.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic tick(input logic start, output out_item_t res);
    in_item_t it;
    it.start_req = start;
    case (ph)
      PH_RST_WAIT: it.bus_level = (byte_cnt == CONV_AFTER_BYTES) ? !sensor_present[1]
                                                                 : !sensor_present[0];
      PH_RD_WAIT:  it.bus_level = sensor_pad[int'(byte_cnt) * 8 + int'(bit_idx)];
      default:     it.bus_level = 1'($urandom_range(0, 1));
    endcase
    send_tick(it, res);
  endtask

  // Hold off the sender until every result is back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (tick_results.size() != 0);
  endtask

  task automatic load_config(input cfg_t c);
    cfg_idx_e    idx;
    logic [19:0] wd;
    logic [9:0]  junk;
    drain_results();
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_e'(i);
      junk = 10'($urandom);
      // upper bits of the narrow registers must be dropped
      case (idx)
        CFG_CONV_WAIT:   wd = c.conv_wait_us;
        CFG_RESET_LOW:   wd = {junk, c.reset_low_us};
        CFG_PRES_SAMPLE: wd = {junk, c.presence_sample_us};
        CFG_RESET_TAIL:  wd = {junk, c.reset_tail_us};
        CFG_SLOT:        wd = {junk, c.slot_us};
        CFG_SHORT_LOW:   wd = {junk, c.short_low_us};
        CFG_READ_SAMPLE: wd = {junk, c.read_sample_us};
        default:         wd = {junk, c.recovery_us};
      endcase
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_wdata_i <= wd;
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cfg = c;
  endtask

  // Start from idle and tick until the sequence ends; pester keeps start high throughout.
  task automatic run_sequence(input logic [1:0] present, input logic [71:0] pad,
                              input bit pester);
    out_item_t res;
    sensor_present = present;
    sensor_pad = pad;
    tick(1'b1, res);
    do tick(pester || $urandom_range(0, 15) == 0, res); while (!res.done_res);
  endtask

  task automatic test_idle_ticks();
    out_item_t res;
    repeat (6) tick(1'b0, res);
  endtask

  task automatic test_reset_timing_no_presence();
    // fields: conv, reset low, presence, tail, slot, short low, read sample, recovery
    load_config(cfg_t'{20'd1, 10'd3, 10'd2, 10'd3, SlotRst, ShortLowRst, ReadSampleRst,
                       RecoveryRst});
    run_sequence(2'b00, sensor_bytes(16'h1234), 1'b1);
  endtask

  task automatic test_slot_saturation();
    // slot below read sample below short low: every released remainder saturates
    load_config(cfg_t'{20'd2, 10'd1, 10'd0, 10'd2, 10'd0, 10'd2, 10'd1, 10'd0});
    run_sequence(2'b11, sensor_bytes(16'hFF5E), 1'b0);
  endtask

  task automatic test_zero_timing();
    load_config(cfg_t'{20'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
    // second reset unanswered: temperature must hold
    run_sequence(2'b01, sensor_bytes(16'h0000), 1'b0);
  endtask

  task automatic test_random_sessions();
    out_item_t res;
    repeat (3) begin
      load_config(random_timing());
      repeat ($urandom_range(0, 4)) tick(1'b0, res);
      // leave the second reset unanswered to keep each session short
      run_sequence({1'b0, $urandom_range(0, 1) != 0}, sensor_bytes(16'($urandom)), 1'b0);
      if ($urandom_range(0, 1) == 0) drain_results();
    end
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    load_config(cfg_t'{20'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
    run_sequence(2'b11, sensor_bytes(16'h7FFF), 1'b0);
  endtask

  always begin : result_sink
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (out_valid_o && out_ready_i) begin
      if (tick_results.size() == 0) begin
        $error("result with no expected item pending");
        mismatches++;
      end else begin
        want = tick_results.pop_front();
        field_check("drive_low", 17'(want.drive_low), 17'(out_item_o.drive_low));
        field_check("busy_res", 17'(want.busy_res), 17'(out_item_o.busy_res));
        field_check("done_res", 17'(want.done_res), 17'(out_item_o.done_res));
        field_check("valid_res", 17'(want.valid_res), 17'(out_item_o.valid_res));
        field_check("no_presence", 17'(want.no_presence), 17'(out_item_o.no_presence));
        field_check("temperature", 17'(want.temperature), 17'(out_item_o.temperature));
        field_check("start_refused", 17'(want.start_refused),
                    17'(out_item_o.start_refused));
      end
    end
  end

  initial begin : watchdog
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : main
    cfg = cfg_t'{ConvWaitRst, ResetLowRst, PresSampleRst, ResetTailRst, SlotRst,
                 ShortLowRst, ReadSampleRst, RecoveryRst};
    ph = PH_IDLE;
    tmr = '0;
    bit_idx = '0;
    byte_cnt = '0;
    shreg = '0;
    lo_byte = '0;
    temp_q = '0;
    flags = '0;
    sensor_present = 2'b11;
    sensor_pad = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_idle_ticks();
    test_reset_timing_no_presence();
    test_slot_saturation();
    test_zero_timing();
    test_random_sessions();
    test_back_to_back();

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/owt_pkg.sv
design/owt_cfg.sv
design/owt_dur.sv
design/owt_seq.sv
design/onewire_temperature_reader.sv
bench/onewire_temperature_reader_tb.sv
